### rtl/mode_pkg.sv
// ============================================================================
// mode_pkg : shared constants and types for the opposite-difference edge block
// Pixel and position widths, line memory geometry, register indexes and
// the stage record carried between the read and compute stages.
// ============================================================================
package mode_pkg;

    // line memory geometry
    localparam int MAX_WIDTH  = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);

    // field widths
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // register reset values and minimum frame size
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [CFG_W-1:0] MIN_SIZE     = 12'd3;

    // item held between memory read and compute
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             res;
        logic             last;
    } t_stage;

    // absolute difference of two pixels
    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

### rtl/max_opposite_difference_edge.sv
// ============================================================================
// max_opposite_difference_edge : 3x3 maximum opposite-difference edge filter
// Raster pixel stream in, one result per interior pixel out. Two line
// memories hold the previous rows; a six-pixel window holds two columns.
// ============================================================================
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  pixel in | i_valid o_ready i_pixel i_frame_start    | in
//  result   | o_valid i_ready o_edge_value o_center_row| out
//           |   o_center_col o_frame_last             |
//  config   | i_cfg_valid o_cfg_ready i_cfg_index      | in
//           |   i_cfg_data                            |
//
//  One item per clock sustained while the output is not stalled. An
//  accepted item enters the compute stage together with its line memory
//  reads (synchronous read), and is computed and written back when it
//  advances, its result landing in the output register that drives o_valid.
//  Reset (synchronous, active low) clears position, window and handshake
//  state; line memory contents stay undefined until written.
//  A stalled output holds a result-producing item in the compute stage, and the input stalls behind it.
//
module max_opposite_difference_edge (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel input
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mode_pkg::PIX_W-1:0]      i_pixel,
    input  logic                            i_frame_start,
    // result output
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mode_pkg::PIX_W-1:0]      o_edge_value,
    output logic [mode_pkg::ROW_W-1:0]      o_center_row,
    output logic [mode_pkg::COL_W-1:0]      o_center_col,
    output logic                            o_frame_last,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mode_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mode_pkg::CFG_W-1:0]      i_cfg_data
);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [mode_pkg::CFG_W-1:0]  r_frame_width;
    logic [mode_pkg::CFG_W-1:0]  r_frame_height;
    logic [mode_pkg::ROW_W-1:0]  r_row;
    logic [mode_pkg::COL_W-1:0]  r_col;

    logic                        r_s1_valid;
    mode_pkg::t_stage            r_s1;
    logic [mode_pkg::PIX_W-1:0]  r_top_rd;
    logic [mode_pkg::PIX_W-1:0]  r_mid_rd;
    logic                        r_fwd;
    logic [mode_pkg::PIX_W-1:0]  r_fwd_top;
    logic [mode_pkg::PIX_W-1:0]  r_fwd_mid;

    logic [mode_pkg::PIX_W-1:0]  r_win [6];

    logic                        r_out_valid;
    logic [mode_pkg::PIX_W-1:0]  r_edge;
    logic [mode_pkg::ROW_W-1:0]  r_out_row;
    logic [mode_pkg::COL_W-1:0]  r_out_col;
    logic                        r_out_last;

    // line memories: row r-2 and row r-1
    logic [mode_pkg::PIX_W-1:0]  r_top_mem [mode_pkg::MAX_WIDTH];
    logic [mode_pkg::PIX_W-1:0]  r_mid_mem [mode_pkg::MAX_WIDTH];

    // ------------------------------------------------------------------
    // effective frame size
    // ------------------------------------------------------------------
    logic [mode_pkg::CFG_W-1:0]  w_eff;
    logic [mode_pkg::CFG_W-1:0]  h_eff;

    always_comb begin
        if (r_frame_width < mode_pkg::MIN_SIZE) begin
            w_eff = mode_pkg::MIN_SIZE;
        end else if (r_frame_width > mode_pkg::CFG_W'(mode_pkg::MAX_WIDTH)) begin
            w_eff = mode_pkg::CFG_W'(mode_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_frame_width;
        end
        h_eff = (r_frame_height < mode_pkg::MIN_SIZE) ? mode_pkg::MIN_SIZE
                                                      : r_frame_height;
    end

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    logic accept;
    logic adv;

    assign adv     = r_s1_valid && (!r_s1.res || !r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || adv;
    assign accept  = i_valid && o_ready;

    // ------------------------------------------------------------------
    // position of the incoming pixel and of the next one
    // ------------------------------------------------------------------
    logic [mode_pkg::ROW_W-1:0]  row0;
    logic [mode_pkg::COL_W-1:0]  col0;
    logic                        col_wrap;
    logic [mode_pkg::ROW_W:0]    row1_ext;
    logic [mode_pkg::ROW_W-1:0]  cur_row;
    logic [mode_pkg::COL_W-1:0]  cur_col;
    logic [mode_pkg::COL_W:0]    col_inc;
    logic [mode_pkg::ROW_W:0]    row_inc;
    logic [mode_pkg::ROW_W-1:0]  n_row;
    logic [mode_pkg::COL_W-1:0]  n_col;
    logic                        cur_res;
    logic                        cur_last;

    always_comb begin
        // frame start and size-change wrap
        row0     = i_frame_start ? '0 : r_row;
        col0     = i_frame_start ? '0 : r_col;
        col_wrap = ({1'b0, col0} >= w_eff);
        row1_ext = col_wrap ? ({1'b0, row0} + 1'b1) : {1'b0, row0};
        if (row1_ext >= {1'b0, h_eff}) begin
            row1_ext = '0;
        end
        cur_row = row1_ext[mode_pkg::ROW_W-1:0];
        cur_col = col_wrap ? '0 : col0;

        // advance to the next pixel
        col_inc = {1'b0, cur_col} + 1'b1;
        row_inc = {1'b0, cur_row} + 1'b1;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[mode_pkg::ROW_W-1:0];
        end else begin
            n_col = col_inc[mode_pkg::COL_W-1:0];
            n_row = cur_row;
        end

        // interior test and last-result flag
        cur_res  = (cur_row >= mode_pkg::ROW_W'(2)) && (cur_col >= mode_pkg::COL_W'(2));
        cur_last = (cur_row == (h_eff - 1'b1)) && ({1'b0, cur_col} == (w_eff - 1'b1));
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mode_pkg::WIDTH_RESET;
            r_frame_height <= mode_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mode_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                mode_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // compute stage: pixels of the 3x3 window with forwarding
    // ------------------------------------------------------------------
    logic [mode_pkg::PIX_W-1:0] top_px;
    logic [mode_pkg::PIX_W-1:0] mid_px;
    logic [mode_pkg::PIX_W-1:0] d_lr;
    logic [mode_pkg::PIX_W-1:0] d_tb;
    logic [mode_pkg::PIX_W-1:0] d_diag_a;
    logic [mode_pkg::PIX_W-1:0] d_diag_b;
    logic [mode_pkg::PIX_W-1:0] max_a;
    logic [mode_pkg::PIX_W-1:0] max_b;
    logic [mode_pkg::PIX_W-1:0] edge_val;
    logic                       fwd_hit;

    assign top_px = r_fwd ? r_fwd_top : r_top_rd;
    assign mid_px = r_fwd ? r_fwd_mid : r_mid_rd;

    // window: [0..2] column c-2 (top, mid, bottom), [3..5] column c-1
    always_comb begin
        d_lr     = mode_pkg::abs_diff(r_win[1], mid_px);
        d_tb     = mode_pkg::abs_diff(r_win[3], r_win[5]);
        d_diag_a = mode_pkg::abs_diff(r_win[0], r_s1.pix);
        d_diag_b = mode_pkg::abs_diff(top_px, r_win[2]);
        max_a    = (d_tb > d_lr) ? d_tb : d_lr;
        max_b    = (d_diag_b > d_diag_a) ? d_diag_b : d_diag_a;
        edge_val = (max_b > max_a) ? max_b : max_a;
    end

    // write-back to the column being read in the same cycle
    assign fwd_hit = adv && (r_s1.col == cur_col);

    // ------------------------------------------------------------------
    // line memories: read on accept, write back on advance
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top_rd <= r_top_mem[mode_pkg::ADDR_W'(cur_col)];
            r_mid_rd <= r_mid_mem[mode_pkg::ADDR_W'(cur_col)];
        end
        if (adv) begin
            r_top_mem[mode_pkg::ADDR_W'(r_s1.col)] <= mid_px;
            r_mid_mem[mode_pkg::ADDR_W'(r_s1.col)] <= r_s1.pix;
        end
    end

    // ------------------------------------------------------------------
    // position, stage and forwarding registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (accept) begin
                r_row      <= n_row;
                r_col      <= n_col;
                r_s1_valid <= 1'b1;
                r_fwd      <= fwd_hit;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
                r_fwd      <= 1'b0;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.pix  <= i_pixel;
            r_s1.row  <= cur_row;
            r_s1.col  <= cur_col;
            r_s1.res  <= cur_res;
            r_s1.last <= cur_last;
            r_fwd_top <= mid_px;
            r_fwd_mid <= r_s1.pix;
        end
    end

    // ------------------------------------------------------------------
    // window shift
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top_px;
            r_win[4] <= mid_px;
            r_win[5] <= r_s1.pix;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_s1.res) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1.res) begin
            r_edge     <= edge_val;
            r_out_row  <= r_s1.row - 1'b1;
            r_out_col  <= r_s1.col - 1'b1;
            r_out_last <= r_s1.last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_edge_value = r_edge;
    assign o_center_row = r_out_row;
    assign o_center_col = r_out_col;
    assign o_frame_last = r_out_last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // forwarded data only stands with an item in the compute stage
    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forward flag set with empty compute stage");

    // an accepted item always occupies the compute stage next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted item lost before compute stage");

    // a result is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !(adv && r_s1.res))
        else $error("pending result overwritten");

    // results only for interior centers
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1.res) |=> (r_out_row != '0) && (r_out_col != '0))
        else $error("result for a border pixel");

endmodule
